@@ rtl/closed_catmull_rom_point_eval_macros.svh @@
// Assertion macros shared by the checker.
// CCR_ASSERT is held off while reset is low; CCR_ASSERT_ANY checks at every edge.
`ifndef CLOSED_CATMULL_ROM_POINT_EVAL_MACROS_SVH
`define CLOSED_CATMULL_ROM_POINT_EVAL_MACROS_SVH

`define CCR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("loop evaluator check failed");

`define CCR_ASSERT_ANY(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("loop evaluator check failed during or after reset");

`endif

@@ rtl/ccr_pkg.sv @@
package ccr_pkg;

    // default coordinate and phase widths
    localparam int COORD_WIDTH_DEF = 16;
    localparam int PHASE_WIDTH_DEF = 16;

    // register packing: three 16-bit lanes in a 48-bit point
    localparam int LANE_BITS  = 16;
    localparam int NUM_AXES   = 3;
    localparam int NUM_POINTS = 4;
    localparam int POINT_BITS = 48;

    // configuration port
    localparam int DATA_BITS = 64;
    localparam int ADDR_BITS = 5;

    // result field widths
    localparam int POS_BITS   = 18;
    localparam int SLOPE_BITS = 20;

    // operand slice for wide multiplies
    localparam int MUL_CHUNK = 24;

    typedef enum logic [1:0] {
        REG_POINT_ZERO,
        REG_POINT_ONE,
        REG_POINT_TWO,
        REG_POINT_THREE
    } reg_idx_t;

    typedef logic [POINT_BITS-1:0] point_t;

endpackage

@@ rtl/ccr_mac.sv @@
// Two-stage multiply-add: y = x * u + addend.
// x is cut into MUL_CHUNK-bit slices; each slice product is registered,
// then the shifted partials and the addend are summed.
module ccr_mac
    import ccr_pkg::*;
#(
    parameter int XW = 44,
    parameter int UW = 14,
    parameter int YW = 60
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x,
    input  logic        [UW-1:0] u,
    input  logic signed [YW-1:0] addend,
    output logic signed [YW-1:0] y
);

    localparam int NC  = (XW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int XEW = NC * MUL_CHUNK;
    localparam int PW  = MUL_CHUNK + UW + 2;

    logic signed [XEW-1:0] x_ext;
    logic signed [UW:0]    u_s;
    logic signed [PW-1:0]  pp_next [NC];
    logic signed [PW-1:0]  pp_reg  [NC];
    logic signed [YW-1:0]  add_reg;
    logic signed [YW-1:0]  y_next;
    logic signed [YW-1:0]  y_reg;

    assign x_ext = XEW'(x);
    assign u_s   = $signed({1'b0, u});

    // slice products: low slices unsigned, top slice carries the sign
    always_comb
    begin
        for (int j = 0; j < NC; j++)
        begin
            if (j == NC - 1)
                pp_next[j] = $signed(x_ext[j*MUL_CHUNK +: MUL_CHUNK]) * u_s;
            else
                pp_next[j] = $signed({1'b0, x_ext[j*MUL_CHUNK +: MUL_CHUNK]}) * u_s;
        end
    end

    // sum of aligned partials
    always_comb
    begin
        logic signed [YW-1:0] acc;
        acc = add_reg;
        for (int j = 0; j < NC; j++)
        begin
            acc = acc + (YW'(pp_reg[j]) <<< (j * MUL_CHUNK));
        end
        y_next = acc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            add_reg <= addend;
            y_reg   <= y_next;
        end
    end

    assign y = y_reg;

endmodule

@@ rtl/ccr_round.sv @@
// Registered round-to-nearest (ties up) by 2^K, then clamp to OW signed bits.
module ccr_round
#(
    parameter int IW = 60,
    parameter int K  = 29,
    parameter int OW = 18
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [IW-1:0] x,
    output logic signed [OW-1:0] y
);

    localparam logic signed [IW:0] HALF  = (IW+1)'(1) << (K - 1);
    localparam logic signed [IW:0] MAX_V = (IW+1)'((64'(1) << (OW - 1)) - 64'(1));
    localparam logic signed [IW:0] MIN_V = ~MAX_V;

    logic signed [IW:0]   sum;
    logic signed [IW:0]   q;
    logic signed [OW-1:0] y_next;
    logic signed [OW-1:0] y_reg;

    always_comb
    begin
        sum = (IW+1)'(x) + HALF;
        q   = sum >>> K;
        if (q > MAX_V)
            y_next = MAX_V[OW-1:0];
        else if (q < MIN_V)
            y_next = MIN_V[OW-1:0];
        else
            y_next = q[OW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

@@ rtl/ccr_axis.sv @@
// One coordinate lane of the evaluator, Horner form in local u:
//   h1 = A0 u + A1 2^F,       d1 = 3 A0 u + 2 A1 2^F
//   h2 = h1 u + A2 2^2F,      dn = d1 u + A2 2^2F
//   pn = h2 u + p1 2^(3F+1)
// Eight register stages from segment/phase in to rounded results out.
module ccr_axis
    import ccr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PHASE_WIDTH = PHASE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_WIDTH-1:0] pt [NUM_POINTS],
    input  logic        [1:0]            seg,
    input  logic        [PHASE_WIDTH-3:0] u,
    output logic signed [POS_BITS-1:0]   pos,
    output logic signed [SLOPE_BITS-1:0] slope
);

    localparam int LW = PHASE_WIDTH - 2;
    localparam int AW = COORD_WIDTH + 4;
    localparam int MW = AW + LW + 1;
    localparam int W1 = AW + LW + 2;
    localparam int W2 = W1 + LW + 2;
    localparam int W3 = W2 + LW + 2;

    // stage 1: pick the four points, form the basis coefficients
    logic        [1:0]    i0, i1, i2, i3;
    logic signed [AW-1:0] e0, e1, e2, e3, d12;
    logic signed [AW-1:0] a0_next, a1_next, a2_next, p1_next;
    logic signed [AW-1:0] a0_reg, a1_reg, a2_reg, p1_reg;
    logic        [LW-1:0] u1_reg;

    assign i0 = seg + 2'd3;
    assign i1 = seg;
    assign i2 = seg + 2'd1;
    assign i3 = seg + 2'd2;

    always_comb
    begin
        e0      = AW'(pt[i0]);
        e1      = AW'(pt[i1]);
        e2      = AW'(pt[i2]);
        e3      = AW'(pt[i3]);
        d12     = e1 - e2;
        a0_next = (d12 <<< 1) + d12 + e3 - e0;
        a1_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        a2_next = e2 - e0;
        p1_next = e1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            a2_reg <= a2_next;
            p1_reg <= p1_next;
            u1_reg <= u;
        end
    end

    // stage 2: A0 * u
    logic signed [MW-1:0] m_next, m_reg;
    logic signed [AW-1:0] a1_d2_reg, a2_d2_reg, p1_d2_reg;
    logic        [LW-1:0] u2_reg;

    assign m_next = a0_reg * $signed({1'b0, u1_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= m_next;
            a1_d2_reg <= a1_reg;
            a2_d2_reg <= a2_reg;
            p1_d2_reg <= p1_reg;
            u2_reg    <= u1_reg;
        end
    end

    // stage 3: first Horner step for position and slope
    logic signed [W1-1:0] h1_next, d1_next, h1_reg, d1_reg;
    logic signed [AW-1:0] a2_d3_reg, p1_d3_reg;
    logic        [LW-1:0] u3_reg;

    always_comb
    begin
        h1_next = W1'(m_reg) + (W1'(a1_d2_reg) <<< LW);
        d1_next = (h1_next <<< 1) + W1'(m_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg    <= h1_next;
            d1_reg    <= d1_next;
            a2_d3_reg <= a2_d2_reg;
            p1_d3_reg <= p1_d2_reg;
            u3_reg    <= u2_reg;
        end
    end

    // stages 4-5: second Horner step, both polynomials
    logic signed [W2-1:0] a2_term, h2, dn;
    logic signed [AW-1:0] p1_d4_reg, p1_d5_reg;
    logic        [LW-1:0] u4_reg, u5_reg;

    assign a2_term = W2'(a2_d3_reg) <<< (2 * LW);

    ccr_mac #(.XW(W1), .UW(LW), .YW(W2)) u_mac_h2
    (
        .clk    (clk),
        .en     (en),
        .x      (h1_reg),
        .u      (u3_reg),
        .addend (a2_term),
        .y      (h2)
    );

    ccr_mac #(.XW(W1), .UW(LW), .YW(W2)) u_mac_dn
    (
        .clk    (clk),
        .en     (en),
        .x      (d1_reg),
        .u      (u3_reg),
        .addend (a2_term),
        .y      (dn)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_d4_reg <= p1_d3_reg;
            p1_d5_reg <= p1_d4_reg;
            u4_reg    <= u3_reg;
            u5_reg    <= u4_reg;
        end
    end

    // stages 6-7: last position step; slope numerator waits alongside
    logic signed [W3-1:0] p1_term, pn;
    logic signed [W2-1:0] dn_d6_reg, dn_d7_reg;

    assign p1_term = W3'(p1_d5_reg) <<< (3 * LW + 1);

    ccr_mac #(.XW(W2), .UW(LW), .YW(W3)) u_mac_pn
    (
        .clk    (clk),
        .en     (en),
        .x      (h2),
        .u      (u5_reg),
        .addend (p1_term),
        .y      (pn)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_d6_reg <= dn;
            dn_d7_reg <= dn_d6_reg;
        end
    end

    // stage 8: round and saturate into the output registers
    ccr_round #(.IW(W3), .K(3 * LW + 1), .OW(POS_BITS)) u_round_pos
    (
        .clk (clk),
        .en  (en),
        .x   (pn),
        .y   (pos)
    );

    ccr_round #(.IW(W2), .K(2 * LW + 1), .OW(SLOPE_BITS)) u_round_slope
    (
        .clk (clk),
        .en  (en),
        .x   (dn_d7_reg),
        .y   (slope)
    );

endmodule

@@ rtl/closed_catmull_rom_point_eval.sv @@
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------------
// phase    | phase_valid / phase_stall   | loop_phase
// result   | result_valid / result_stall | pos_x pos_y pos_z slope_x slope_y slope_z
// config   | psel penable pwrite pready  | paddr pwdata prdata (point i at 8*i)
//
// One item per cycle sustained while no result waits under result_stall; each item
// passes nine register stages before result_valid (input register, coefficient stage,
// one A0*u stage, one Horner add stage, two sliced multiply-adds, round/saturate).
// The whole pipeline advances together: phase_stall is high only while a
// result waits under result_stall, and then every stage holds.
// rst_n clears the valid bits and the four control points.
module closed_catmull_rom_point_eval
    import ccr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int PHASE_WIDTH = PHASE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         phase_valid,
    output logic                         phase_stall,
    input  logic        [PHASE_WIDTH-1:0] loop_phase,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [POS_BITS-1:0]   pos_x,
    output logic signed [POS_BITS-1:0]   pos_y,
    output logic signed [POS_BITS-1:0]   pos_z,
    output logic signed [SLOPE_BITS-1:0] slope_x,
    output logic signed [SLOPE_BITS-1:0] slope_y,
    output logic signed [SLOPE_BITS-1:0] slope_z,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [ADDR_BITS-1:0]  paddr,
    input  logic        [DATA_BITS-1:0]  pwdata,
    output logic        [DATA_BITS-1:0]  prdata,
    output logic                         pready
);

    localparam int LW          = PHASE_WIDTH - 2;
    localparam int PIPE_STAGES = 9;

    // control point registers
    point_t   point_reg  [NUM_POINTS];
    point_t   point_next [NUM_POINTS];
    point_t   rd_point;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:ADDR_BITS-2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        point_next = point_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_POINT_ZERO:  point_next[0] = pwdata[POINT_BITS-1:0];
                REG_POINT_ONE:   point_next[1] = pwdata[POINT_BITS-1:0];
                REG_POINT_TWO:   point_next[2] = pwdata[POINT_BITS-1:0];
                REG_POINT_THREE: point_next[3] = pwdata[POINT_BITS-1:0];
                default:         point_next = point_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
                point_reg[i] <= '0;
        end
        else
        begin
            point_reg <= point_next;
        end
    end

    // register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_POINT_ZERO:  rd_point = point_reg[0];
            REG_POINT_ONE:   rd_point = point_reg[1];
            REG_POINT_TWO:   rd_point = point_reg[2];
            REG_POINT_THREE: rd_point = point_reg[3];
            default:         rd_point = '0;
        endcase
    end

    assign prdata = DATA_BITS'(rd_point);

    // pipeline advance and valid bits
    logic                   en;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;

    assign en           = !(valid_reg[PIPE_STAGES-1] && result_stall);
    assign phase_stall  = !en;
    assign result_valid = valid_reg[PIPE_STAGES-1];
    assign valid_next   = {valid_reg[PIPE_STAGES-2:0], phase_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // input register
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [1:0]             seg;
    logic [LW-1:0]          u_local;

    always_ff @(posedge clk)
    begin
        if (en)
            phase_reg <= loop_phase;
    end

    assign seg     = phase_reg[PHASE_WIDTH-1 -: 2];
    assign u_local = phase_reg[LW-1:0];

    // one evaluation lane per axis
    logic signed [POS_BITS-1:0]   pos_w   [NUM_AXES];
    logic signed [SLOPE_BITS-1:0] slope_w [NUM_AXES];

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        logic signed [COORD_WIDTH-1:0] pts [NUM_POINTS];

        for (genvar i = 0; i < NUM_POINTS; i++)
        begin : g_pt
            assign pts[i] = point_reg[i][LANE_BITS*a +: COORD_WIDTH];
        end

        ccr_axis #(.COORD_WIDTH(COORD_WIDTH), .PHASE_WIDTH(PHASE_WIDTH)) u_axis
        (
            .clk   (clk),
            .en    (en),
            .pt    (pts),
            .seg   (seg),
            .u     (u_local),
            .pos   (pos_w[a]),
            .slope (slope_w[a])
        );
    end

    assign pos_x   = pos_w[0];
    assign pos_y   = pos_w[1];
    assign pos_z   = pos_w[2];
    assign slope_x = slope_w[0];
    assign slope_y = slope_w[1];
    assign slope_z = slope_w[2];

endmodule

@@ rtl/closed_catmull_rom_point_eval_checker.sv @@
`include "closed_catmull_rom_point_eval_macros.svh"

// Port-level checks for the loop evaluator.
module closed_catmull_rom_point_eval_checker
    import ccr_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         phase_valid,
    input logic                         phase_stall,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic signed [POS_BITS-1:0]   pos_x,
    input logic signed [POS_BITS-1:0]   pos_y,
    input logic signed [POS_BITS-1:0]   pos_z,
    input logic signed [SLOPE_BITS-1:0] slope_x,
    input logic signed [SLOPE_BITS-1:0] slope_y,
    input logic signed [SLOPE_BITS-1:0] slope_z,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic        [ADDR_BITS-1:0]  paddr,
    input logic        [DATA_BITS-1:0]  pwdata,
    input logic        [DATA_BITS-1:0]  prdata,
    input logic                         pready
);

    // config port never waits
    `CCR_ASSERT_ANY(a_pready_high, pready)

    // input side backs up only behind a waiting, stalled result
    `CCR_ASSERT(a_stall_tracks_output, phase_stall == (result_valid && result_stall))

    // a stalled result holds until taken
    `CCR_ASSERT(a_result_holds, result_valid && result_stall |=> result_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(slope_x) && $stable(slope_y) && $stable(slope_z))

    // a point reads back what was just written to it
    `CCR_ASSERT(a_readback, (psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr)) |-> prdata == DATA_BITS'($past(pwdata[POINT_BITS-1:0])))

endmodule

bind closed_catmull_rom_point_eval closed_catmull_rom_point_eval_checker u_checker (.*);
